[design/bounded_double_ended_queue_core_defines.svh]
// Assertion macros for the deque core.
// Define NO_ASSERTIONS to compile them out.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define BDQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque assertion failed");

// Next-cycle implication.
`define BDQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque assertion failed");

`else

`define BDQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BDQ_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

[design/bdq_pkg.sv]
package bdq_pkg;

	localparam int ELEM_W = 8;
	localparam int KIND_W = 3;

	typedef enum logic [KIND_W-1:0] {
		K_PUSH_FRONT = 3'd0,
		K_PUSH_REAR  = 3'd1,
		K_POP_FRONT  = 3'd2,
		K_POP_REAR   = 3'd3,
		K_PEEK_FRONT = 3'd4,
		K_PEEK_REAR  = 3'd5
	} kind_t;

	// controller -> cell ring: write into the cell that wraps around
	typedef struct packed {
		logic              wr;
		logic [ELEM_W-1:0] wdata;
	} ring_ctl_t;

endpackage

[design/bdq_cell.sv]
module bdq_cell
	import bdq_pkg::*;
(
	input  logic              clk,
	input  logic              ld,
	input  logic [ELEM_W-1:0] ld_data,
	input  logic [ELEM_W-1:0] nbr,
	output logic [ELEM_W-1:0] data
);

	logic [ELEM_W-1:0] data_q;

	// take the neighbor's byte every cycle, or a new byte on load
	always_ff @(posedge clk) begin
		data_q <= ld ? ld_data : nbr;
	end

	assign data = data_q;

endmodule

[design/bdq_ctrl.sv]
`include "bounded_double_ended_queue_core_defines.svh"

module bdq_ctrl
	import bdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [KIND_W-1:0]          kind,
	input  logic [ELEM_W-1:0]          push_value,
	output logic                       busy,
	output logic                       done,
	output logic                       ok,
	output logic [ELEM_W-1:0]          out_value,
	output logic [$clog2(DEPTH+1)-1:0] count_after,
	output logic                       now_empty,
	input  logic [ELEM_W-1:0]          cell0,
	output ring_ctl_t                  ring_ctl
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
	localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SEEK = 3'b010,
		ST_RESP = 3'b100
	} state_t;

	state_t          state_q;
	logic [IW-1:0]   head_q;
	logic [CW-1:0]   cnt_q;
	logic [IW-1:0]   rot_q;     // ring slot now sitting in cell 0

	logic [IW-1:0]   pos_q;
	logic            push_q;
	logic            rd_q;
	logic [ELEM_W-1:0] val_q;

	logic            res_ok_q;
	logic [ELEM_W-1:0] res_val_q;
	logic [CW-1:0]   res_cnt_q;
	logic            res_empty_q;

	logic            acc;
	logic            hit;
	logic            full;
	logic            empty;
	logic [IW-1:0]   head_dec;
	logic [IW-1:0]   head_inc;
	logic [CW:0]     sum_tail;
	logic [CW:0]     sum_last;
	logic [IW-1:0]   tail_pos;
	logic [IW-1:0]   last_pos;

	logic            ok_n;
	logic            push_n;
	logic            rd_n;
	logic [IW-1:0]   pos_n;
	logic [IW-1:0]   head_n;
	logic [CW-1:0]   cnt_n;

	assign busy  = (state_q == ST_SEEK);
	assign acc   = start && !busy;
	assign hit   = (state_q == ST_SEEK) && (rot_q == pos_q);
	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);

	assign head_dec = (head_q == '0) ? LAST_IX : head_q - 1'b1;
	assign head_inc = (head_q == LAST_IX) ? '0 : head_q + 1'b1;

	// ring positions of the free slot after the rear and of the rear element
	assign sum_tail = (CW + 1)'(head_q) + (CW + 1)'(cnt_q);
	assign sum_last = sum_tail - 1'b1;
	assign tail_pos = (sum_tail >= DEPTH_W) ? IW'(sum_tail - DEPTH_W) : IW'(sum_tail);
	assign last_pos = (sum_last >= DEPTH_W) ? IW'(sum_last - DEPTH_W) : IW'(sum_last);

	always_comb begin
		ok_n   = 1'b0;
		push_n = 1'b0;
		rd_n   = 1'b0;
		pos_n  = head_q;
		head_n = head_q;
		cnt_n  = cnt_q;
		case (kind_t'(kind))
			K_PUSH_FRONT: begin
				if (!full) begin
					ok_n   = 1'b1;
					push_n = 1'b1;
					pos_n  = head_dec;
					head_n = head_dec;
					cnt_n  = cnt_q + 1'b1;
				end
			end
			K_PUSH_REAR: begin
				if (!full) begin
					ok_n   = 1'b1;
					push_n = 1'b1;
					pos_n  = tail_pos;
					cnt_n  = cnt_q + 1'b1;
				end
			end
			K_POP_FRONT: begin
				if (!empty) begin
					ok_n   = 1'b1;
					rd_n   = 1'b1;
					pos_n  = head_q;
					head_n = head_inc;
					cnt_n  = cnt_q - 1'b1;
				end
			end
			K_POP_REAR: begin
				if (!empty) begin
					ok_n  = 1'b1;
					rd_n  = 1'b1;
					pos_n = last_pos;
					cnt_n = cnt_q - 1'b1;
				end
			end
			K_PEEK_FRONT: begin
				if (!empty) begin
					ok_n  = 1'b1;
					rd_n  = 1'b1;
					pos_n = head_q;
				end
			end
			K_PEEK_REAR: begin
				if (!empty) begin
					ok_n  = 1'b1;
					rd_n  = 1'b1;
					pos_n = last_pos;
				end
			end
			default: begin
				ok_n = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
			rot_q   <= '0;
		end else begin
			rot_q <= (rot_q == LAST_IX) ? '0 : rot_q + 1'b1;
			if (acc) begin
				head_q  <= head_n;
				cnt_q   <= cnt_n;
				state_q <= ok_n ? ST_SEEK : ST_RESP;
			end else begin
				case (state_q)
					ST_SEEK: begin
						if (hit) begin
							state_q <= ST_RESP;
						end
					end
					ST_RESP: begin
						state_q <= ST_IDLE;
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pos_q       <= pos_n;
			push_q      <= push_n;
			rd_q        <= rd_n;
			val_q       <= push_value;
			res_cnt_q   <= cnt_n;
			res_empty_q <= (cnt_n == '0);
			if (!ok_n) begin
				res_ok_q  <= 1'b0;
				res_val_q <= '0;
			end
		end else if (hit) begin
			res_ok_q  <= 1'b1;
			res_val_q <= rd_q ? cell0 : '0;
		end
	end

	assign ring_ctl.wr    = hit && push_q;
	assign ring_ctl.wdata = val_q;

	assign done        = (state_q == ST_RESP);
	assign ok          = res_ok_q;
	assign out_value   = res_val_q;
	assign count_after = res_cnt_q;
	assign now_empty   = res_empty_q;

	`BDQ_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(DEPTH))
	`BDQ_ASSERT_NXT(a_hit_resp, clk, arst_n, hit, done)
	`BDQ_ASSERT_IMP(a_empty_flag, clk, arst_n, done, now_empty == (count_after == '0))
	`BDQ_ASSERT_IMP(a_fail_zero, clk, arst_n, done && !ok, out_value == '0)

endmodule

[design/bounded_double_ended_queue_core.sv]
// channel  | handshake               | payload
// ---------+-------------------------+------------------------------------------
// command  | start, busy (out)       | kind, push_value
// result   | done (one-cycle strobe) | ok, out_value, count_after, now_empty
//
// A command transaction is taken when start is high and busy is low.
// Elements sit in a ring of DEPTH byte cells that rotates by one place every
// cycle; cell 0 is the only read port and the last cell the only write port.
// A command that succeeds waits until its target slot passes cell 0 before
// its done strobe; a failed or unused command does not wait for any slot.
// busy is high only while a command waits for its slot, so a new command can
// be taken in the cycle its predecessor's result is shown.
// arst_n clears the front index, the count, the rotation and the control
// state; cell contents are not reset. The result side cannot stall: done is
// high for exactly one cycle per command.
module bounded_double_ended_queue_core
	import bdq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [KIND_W-1:0]          kind,
	input  logic [ELEM_W-1:0]          push_value,
	output logic                       busy,
	output logic                       done,
	output logic                       ok,
	output logic [ELEM_W-1:0]          out_value,
	output logic [$clog2(DEPTH+1)-1:0] count_after,
	output logic                       now_empty
);

	// cell_data[i] holds ring slot (rot + i) mod DEPTH
	logic [ELEM_W-1:0] cell_data [DEPTH];
	ring_ctl_t         ring_ctl;

	// Controller: front index, count, rotation phase and result registers.
	bdq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.kind       (kind),
		.push_value (push_value),
		.busy       (busy),
		.done       (done),
		.ok         (ok),
		.out_value  (out_value),
		.count_after(count_after),
		.now_empty  (now_empty),
		.cell0      (cell_data[0]),
		.ring_ctl   (ring_ctl)
	);

	// Rotating row of cells. Each cell takes its upper neighbor; the last cell
	// wraps from cell 0, or takes the pushed byte when the target slot passes.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		if (i == DEPTH - 1) begin : g_last
			bdq_cell u_cell (
				.clk    (clk),
				.ld     (ring_ctl.wr),
				.ld_data(ring_ctl.wdata),
				.nbr    (cell_data[0]),
				.data   (cell_data[i])
			);
		end else begin : g_mid
			bdq_cell u_cell (
				.clk    (clk),
				.ld     (1'b0),
				.ld_data(ring_ctl.wdata),
				.nbr    (cell_data[i+1]),
				.data   (cell_data[i])
			);
		end
	end

endmodule

[bench/bounded_double_ended_queue_core_tb.sv]
`timescale 1ns / 100ps

// Deque core bench: commands go in over start/busy and results come back on done.
// Every accepted command is run through a behavioral deque kept here. That
// yields the reply the core owes for that command, and the monitor checks
// replies in order as done strobes arrive.
module bounded_double_ended_queue_core_tb;
	import bdq_pkg::*;

	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// kind codes the core must treat as no-ops
	localparam logic [KIND_W-1:0] OP_SPARE_A = 3'd6;
	localparam logic [KIND_W-1:0] OP_SPARE_B = 3'd7;

	// worst case: a successful command waits a full ring turn
	localparam int SETTLE_CYCLES = DEPTH + 4;

	typedef struct packed {
		logic [KIND_W-1:0] op;
		logic [ELEM_W-1:0] data;
		logic              calm;	// no idle cycles after this command
	} cmd_t;

	typedef struct packed {
		logic              ok;
		logic [ELEM_W-1:0] out_value;
		logic [CNT_W-1:0]  count_after;
		logic              now_empty;
	} reply_t;

	// bias of a random burst: mostly pushes, mostly pops, or balanced
	typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [KIND_W-1:0] kind = '0;
	logic [ELEM_W-1:0] push_value = '0;
	logic              busy;
	logic              done;
	logic              ok;
	logic [ELEM_W-1:0] out_value;
	logic [CNT_W-1:0]  count_after;
	logic              now_empty;

	cmd_t   pending[$];		// commands not yet handed to the driver
	reply_t replies_due[$];		// predicted replies, oldest first
	logic   took = 1'b0;		// command on the bus was accepted at the last rising edge
	int     gap_left = 0;
	int     errors = 0;

	// behavioral deque: ring storage, front index and fill count
	logic [ELEM_W-1:0] ring_mem[DEPTH];
	int unsigned       front_idx = 0;
	int unsigned       fill_cnt = 0;

	bounded_double_ended_queue_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.kind       (kind),
		.push_value (push_value),
		.busy       (busy),
		.done       (done),
		.ok         (ok),
		.out_value  (out_value),
		.count_after(count_after),
		.now_empty  (now_empty)
	);

	always #6 clk = ~clk;

	// Apply one command to the behavioral deque and return the reply it owes.
	// Failed pushes, failed pops/peeks and spare codes leave the state alone
	// and return a zero byte.
	function automatic reply_t apply_cmd(input logic [KIND_W-1:0] op,
			input logic [ELEM_W-1:0] data);
		reply_t      r;
		int unsigned slot;
		r = '0;
		slot = (front_idx + fill_cnt + DEPTH - 1) % DEPTH;	// rear slot
		case (op)
		K_PUSH_FRONT: begin
			if (fill_cnt < DEPTH) begin
				front_idx = (front_idx + DEPTH - 1) % DEPTH;
				ring_mem[front_idx] = data;
				fill_cnt++;
				r.ok = 1'b1;
			end
		end
		K_PUSH_REAR: begin
			if (fill_cnt < DEPTH) begin
				ring_mem[(front_idx + fill_cnt) % DEPTH] = data;
				fill_cnt++;
				r.ok = 1'b1;
			end
		end
		K_POP_FRONT: begin
			if (fill_cnt != 0) begin
				r.out_value = ring_mem[front_idx];
				front_idx = (front_idx + 1) % DEPTH;
				fill_cnt--;
				r.ok = 1'b1;
			end
		end
		K_POP_REAR: begin
			if (fill_cnt != 0) begin
				r.out_value = ring_mem[slot];
				fill_cnt--;
				r.ok = 1'b1;
			end
		end
		K_PEEK_FRONT: begin
			if (fill_cnt != 0) begin
				r.out_value = ring_mem[front_idx];
				r.ok = 1'b1;
			end
		end
		K_PEEK_REAR: begin
			if (fill_cnt != 0) begin
				r.out_value = ring_mem[slot];
				r.ok = 1'b1;
			end
		end
		default: ;
		endcase
		r.count_after = CNT_W'(fill_cnt);
		r.now_empty = (fill_cnt == 0);
		return r;
	endfunction

	task automatic queue_cmd(input logic [KIND_W-1:0] op, input logic [ELEM_W-1:0] data);
		pending.push_back(cmd_t'{op: op, data: data, calm: 1'b0});
	endtask

	// Queue n random commands biased by lean. Pops/peeks on an empty deque and
	// pushes on a full one come up naturally as the fill level wanders.
	task automatic queue_burst(input int n, input lean_t lean, input logic calm);
		cmd_t c;
		int   pick;
		int   push_lim;
		int   pop_lim;
		push_lim = (lean == LEAN_FILL) ? 70 : (lean == LEAN_DRAIN) ? 20 : 45;
		pop_lim  = push_lim + ((lean == LEAN_FILL) ? 18 : (lean == LEAN_DRAIN) ? 65 : 35);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < push_lim)
				c.op = $urandom_range(0, 1) ? K_PUSH_REAR : K_PUSH_FRONT;
			else if (pick < pop_lim)
				c.op = $urandom_range(0, 1) ? K_POP_REAR : K_POP_FRONT;
			else if (pick < 98)
				c.op = $urandom_range(0, 1) ? K_PEEK_REAR : K_PEEK_FRONT;
			else
				c.op = $urandom_range(0, 1) ? OP_SPARE_B : OP_SPARE_A;
			c.data = $urandom_range(0, 255);
			c.calm = calm;
			pending.push_back(c);
		end
	endtask

	// Returns at a rising edge once every command went in and every reply came
	// back; the conditions are looked at just after falling edges, once the
	// driver's updates have landed.
	task automatic wait_drained();
		do begin
			@(negedge clk);
			#1;
		end while (pending.size() != 0 || start || replies_due.size() != 0);
		@(posedge clk);
	endtask

	// Driver: drives on falling edges. A command stays on the bus until the
	// core takes it; random idle bursts follow some transactions.
	always @(negedge clk) begin
		cmd_t c;
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took) begin
			// core still busy, keep the command on the bus
		end else if (gap_left != 0) begin
			gap_left <= gap_left - 1;
			start <= 1'b0;
		end else if (pending.size() != 0) begin
			c = pending.pop_front();
			start <= 1'b1;
			kind <= c.op;
			push_value <= c.data;
			if (!c.calm && $urandom_range(0, 3) == 0)
				gap_left <= $urandom_range(1, 5);
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: samples on rising edges. The reply for an earlier command is
	// checked before a command taken at the same edge is predicted.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			took <= start && !busy;
			if (done) begin
				if (replies_due.size() == 0) begin
					$error("done strobe with no command outstanding");
					errors++;
				end else begin
					want = replies_due.pop_front();
					if (ok !== want.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, ok);
						errors++;
					end
					if (out_value !== want.out_value) begin
						$error("out_value: expected 0x%02h, got 0x%02h",
							want.out_value, out_value);
						errors++;
					end
					if (count_after !== want.count_after) begin
						$error("count_after: expected %0d, got %0d",
							want.count_after, count_after);
						errors++;
					end
					if (now_empty !== want.now_empty) begin
						$error("now_empty: expected %0d, got %0d",
							want.now_empty, now_empty);
						errors++;
					end
				end
			end
			if (start && !busy)
				replies_due.push_back(apply_cmd(kind, push_value));
		end
	end

	initial begin
		int  sent;
		int  n;
		bit  paused;

		// Directed: every failure on an empty deque, the spare codes, both
		// ends with the extreme bytes, peeks that must not move anything.
		queue_cmd(K_POP_FRONT, 8'hFF);
		queue_cmd(K_POP_REAR, 8'hFF);
		queue_cmd(K_PEEK_FRONT, 8'h00);
		queue_cmd(K_PEEK_REAR, 8'h00);
		queue_cmd(OP_SPARE_A, 8'hFF);
		queue_cmd(OP_SPARE_B, 8'h00);
		queue_cmd(K_PUSH_FRONT, 8'hFF);
		queue_cmd(K_PUSH_REAR, 8'h00);
		queue_cmd(K_PEEK_FRONT, 8'h00);
		queue_cmd(K_PEEK_REAR, 8'hFF);
		queue_cmd(K_POP_REAR, 8'h00);
		queue_cmd(K_POP_FRONT, 8'h00);
		// front push wraps the head below slot 0
		queue_cmd(K_PUSH_REAR, 8'hA5);
		queue_cmd(K_PUSH_FRONT, 8'h5A);
		queue_cmd(OP_SPARE_B, 8'hFF);
		queue_cmd(K_PEEK_REAR, 8'h00);
		queue_cmd(K_POP_FRONT, 8'hFF);
		queue_cmd(K_POP_REAR, 8'hFF);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait_drained();

		// Random bursts; halfway through, the sender holds off until the
		// core has answered everything.
		sent = 0;
		paused = 0;
		while (sent < 800) begin
			n = $urandom_range(20, 60);
			queue_burst(n, lean_t'($urandom_range(0, 2)), 1'b0);
			sent += n;
			if (!paused && sent >= 400) begin
				wait_drained();
				paused = 1;
			end
		end
		// closing stretch back to back: fill up past full, then drain
		queue_burst(50, LEAN_FILL, 1'b1);
		queue_burst(50, LEAN_DRAIN, 1'b1);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("bounded_double_ended_queue_core_tb: clean");
		else
			$display("bounded_double_ended_queue_core_tb: errors");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5000000;
		$display("bounded_double_ended_queue_core_tb: errors");
		$finish;
	end

endmodule
